// ===== rtl/core/jsv_pkg.sv =====
// Package of shared types, codes and tables for the JSON syntax checker.
package jsv_pkg;

  // One input request: a text byte or the end-of-text marker.
  typedef struct packed {
    logic       mode;
    logic [7:0] text_byte;
  } jsv_in_t;

  // One result: the status and, on error, its position.
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] error_line;
    logic [31:0] error_column;
  } jsv_out_t;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRAILING  = 4'd1;
  localparam logic [3:0] ST_UNEXP     = 4'd2;
  localparam logic [3:0] ST_LITERAL   = 4'd3;
  localparam logic [3:0] ST_COLON     = 4'd4;
  localparam logic [3:0] ST_OBJ_SEP   = 4'd5;
  localparam logic [3:0] ST_ARR_SEP   = 4'd6;
  localparam logic [3:0] ST_NUMBER    = 4'd7;
  localparam logic [3:0] ST_EXPONENT  = 4'd8;
  localparam logic [3:0] ST_QUOTE     = 4'd9;
  localparam logic [3:0] ST_ESC_END   = 4'd10;
  localparam logic [3:0] ST_BAD_ESC   = 4'd11;
  localparam logic [3:0] ST_UNTERM    = 4'd12;
  localparam logic [3:0] ST_TOO_DEEP  = 4'd13;

  // Parser phases.
  localparam logic [4:0] PH_VALUE         = 5'd0;
  localparam logic [4:0] PH_ARR_FIRST     = 5'd1;
  localparam logic [4:0] PH_OBJ_FIRST     = 5'd2;
  localparam logic [4:0] PH_OBJ_KEY       = 5'd3;
  localparam logic [4:0] PH_STR           = 5'd4;
  localparam logic [4:0] PH_STR_ESC       = 5'd5;
  localparam logic [4:0] PH_KEY           = 5'd6;
  localparam logic [4:0] PH_KEY_ESC       = 5'd7;
  localparam logic [4:0] PH_COLON         = 5'd8;
  localparam logic [4:0] PH_AFTER         = 5'd9;
  localparam logic [4:0] PH_LIT           = 5'd10;
  localparam logic [4:0] PH_NUM_SIGN      = 5'd11;
  localparam logic [4:0] PH_NUM_INT       = 5'd12;
  localparam logic [4:0] PH_NUM_FRAC      = 5'd13;
  localparam logic [4:0] PH_NUM_EXP       = 5'd14;
  localparam logic [4:0] PH_NUM_EXP_SIGN  = 5'd15;
  localparam logic [4:0] PH_NUM_EXP_DIG   = 5'd16;

  // Stack commands from the parser.
  typedef struct packed {
    logic push;
    logic pop;
    logic push_obj;
    logic clear;
  } jsv_nest_ctrl_t;

  // Stack status seen by the parser.
  typedef struct packed {
    logic empty;
    logic full;
    logic top_obj;
  } jsv_nest_stat_t;

  // Outcome of one parser step.
  typedef struct packed {
    logic [4:0] phase;
    logic [1:0] lit_kind;
    logic [2:0] lit_prog;
    logic       tok_capture;
    logic [3:0] err;
    logic       err_at_tok;
    logic       push;
    logic       pop;
    logic       push_obj;
  } jsv_step_t;

  // Expected character of a literal at a given place.
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      2'd1: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  // Length of a literal.
  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      2'd1:    len = 3'd5;
      2'd2:    len = 3'd4;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/jsv_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module jsv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/jsv_nest.sv =====
// Nesting stack: top and second entries in registers, deeper entries in a RAM.
module jsv_nest #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  jsv_pkg::jsv_nest_ctrl_t ctrl_i,
  output jsv_pkg::jsv_nest_stat_t stat_o
);
  import jsv_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [LW-1:0] level_q, level_d;
  logic          top_q, top_d;
  logic          second_q, second_d;
  logic          sec_rd_q, sec_rd_d;
  logic          second;
  logic          rd_data;
  logic          we;
  logic [LW-1:0] waddr_full, raddr_full;

  // The second entry comes from the RAM after a pop, else from its register.
  assign second = sec_rd_q ? rd_data : second_q;

  // Next stack state.
  always_comb begin
    level_d  = level_q;
    top_d    = top_q;
    second_d = second_q;
    sec_rd_d = sec_rd_q;
    we       = 1'b0;
    if (ctrl_i.clear) begin
      level_d  = '0;
      sec_rd_d = 1'b0;
    end else if (ctrl_i.push) begin
      level_d  = level_q + 1'b1;
      top_d    = ctrl_i.push_obj;
      second_d = top_q;
      sec_rd_d = 1'b0;
      we       = (level_q != '0);
    end else if (ctrl_i.pop && level_q != '0) begin
      level_d  = level_q - 1'b1;
      top_d    = second;
      sec_rd_d = 1'b1;
    end
  end

  // Old top is stored at its own index; the read fetches the new second entry.
  assign waddr_full = level_q - 1'b1;
  assign raddr_full = level_d - LW'(2);

  jsv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(waddr_full)),
    .wdata_i (top_q),
    .raddr_i (AW'(raddr_full)),
    .rdata_o (rd_data)
  );

  // Stack registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      sec_rd_q <= 1'b0;
      top_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      level_q  <= level_d;
      sec_rd_q <= sec_rd_d;
      top_q    <= top_d;
      second_q <= second_d;
    end
  end

  assign stat_o.empty   = (level_q == '0);
  assign stat_o.full    = (level_q == LW'(MAX_DEPTH));
  assign stat_o.top_obj = (level_q != '0) && top_q;

endmodule

// ===== rtl/core/jsv_parse.sv =====
// Parser step: next phase, literal progress, stack command and error for one byte.
module jsv_parse (
  input  logic [4:0]              phase_i,
  input  logic [7:0]              char_i,
  input  jsv_pkg::jsv_nest_stat_t nest_i,
  input  logic [1:0]              lit_kind_i,
  input  logic [2:0]              lit_prog_i,
  output jsv_pkg::jsv_step_t      step_o,
  output logic [3:0]              end_err_o,
  output logic                    end_err_at_tok_o
);
  import jsv_pkg::*;

  logic       is_ws, is_digit, is_exp;
  logic       done;
  logic [4:0] ph;
  logic [1:0] kind;
  logic [2:0] len;
  logic [7:0] want;

  assign is_ws    = (char_i == " ") || (char_i == 8'h09) || (char_i == 8'h0d) ||
                    (char_i == 8'h0a);
  assign is_digit = (char_i >= "0") && (char_i <= "9");
  assign is_exp   = (char_i == "e") || (char_i == "E");
  assign kind     = (lit_kind_i == 2'd3) ? 2'd0 : lit_kind_i;
  assign len      = lit_len(kind);
  assign want     = lit_char(kind, lit_prog_i);

  // Byte step: number phases first, then the general phase handling.
  always_comb begin
    step_o          = '0;
    step_o.phase    = phase_i;
    step_o.lit_kind = lit_kind_i;
    step_o.lit_prog = lit_prog_i;
    done            = 1'b1;
    case (phase_i)
      PH_NUM_SIGN: begin
        if (is_digit) step_o.phase = PH_NUM_INT;
        else step_o.err = ST_NUMBER;
      end
      PH_NUM_INT: begin
        if (is_digit) step_o.phase = PH_NUM_INT;
        else if (char_i == ".") step_o.phase = PH_NUM_FRAC;
        else if (is_exp) step_o.phase = PH_NUM_EXP;
        else done = 1'b0;
      end
      PH_NUM_FRAC: begin
        if (is_digit) step_o.phase = PH_NUM_FRAC;
        else if (is_exp) step_o.phase = PH_NUM_EXP;
        else done = 1'b0;
      end
      PH_NUM_EXP: begin
        if (char_i == "+" || char_i == "-") step_o.phase = PH_NUM_EXP_SIGN;
        else if (is_digit) step_o.phase = PH_NUM_EXP_DIG;
        else step_o.err = ST_EXPONENT;
      end
      PH_NUM_EXP_SIGN: begin
        if (is_digit) step_o.phase = PH_NUM_EXP_DIG;
        else step_o.err = ST_EXPONENT;
      end
      PH_NUM_EXP_DIG: begin
        if (!is_digit) done = 1'b0;
      end
      default: done = 1'b0;
    endcase

    // A number that ends hands the byte that ends it on as a byte after a value.
    ph = (phase_i >= PH_NUM_INT && phase_i != PH_NUM_EXP && phase_i != PH_NUM_EXP_SIGN &&
          phase_i <= PH_NUM_EXP_DIG) ? PH_AFTER : phase_i;

    if (!done) begin
      step_o.phase = ph;
      case (ph)
        PH_VALUE, PH_ARR_FIRST: begin
          if (is_ws) begin
            step_o.phase = ph;
          end else if (ph == PH_ARR_FIRST && char_i == "]") begin
            step_o.pop   = 1'b1;
            step_o.phase = PH_AFTER;
          end else if (char_i == "\"") begin
            step_o.phase = PH_STR;
          end else if (char_i == "{" || char_i == "[") begin
            if (nest_i.full) begin
              step_o.err = ST_TOO_DEEP;
            end else begin
              step_o.push     = 1'b1;
              step_o.push_obj = (char_i == "{");
              step_o.phase    = (char_i == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
            end
          end else if (char_i == "t" || char_i == "f" || char_i == "n") begin
            step_o.lit_kind    = (char_i == "t") ? 2'd0 : (char_i == "f") ? 2'd1 : 2'd2;
            step_o.lit_prog    = 3'd1;
            step_o.tok_capture = 1'b1;
            step_o.phase       = PH_LIT;
          end else if (char_i == "-") begin
            step_o.phase = PH_NUM_SIGN;
          end else if (is_digit) begin
            step_o.phase = PH_NUM_INT;
          end else begin
            step_o.err = ST_UNEXP;
          end
        end
        PH_OBJ_FIRST, PH_OBJ_KEY: begin
          if (!is_ws) begin
            if (char_i == "}" && ph == PH_OBJ_FIRST) begin
              step_o.pop   = 1'b1;
              step_o.phase = PH_AFTER;
            end else if (char_i == "\"") begin
              step_o.phase = PH_KEY;
            end else begin
              step_o.err = ST_QUOTE;
            end
          end
        end
        PH_STR: begin
          if (char_i == "\"") step_o.phase = PH_AFTER;
          else if (char_i == "\\") step_o.phase = PH_STR_ESC;
        end
        PH_KEY: begin
          if (char_i == "\"") step_o.phase = PH_COLON;
          else if (char_i == "\\") step_o.phase = PH_KEY_ESC;
        end
        PH_STR_ESC, PH_KEY_ESC: begin
          if (char_i == "\"" || char_i == "\\") begin
            step_o.phase = (ph == PH_STR_ESC) ? PH_STR : PH_KEY;
          end else begin
            step_o.err = ST_BAD_ESC;
          end
        end
        PH_COLON: begin
          if (!is_ws) begin
            if (char_i == ":") step_o.phase = PH_VALUE;
            else step_o.err = ST_COLON;
          end
        end
        PH_AFTER: begin
          if (!is_ws) begin
            if (nest_i.empty) begin
              step_o.err = ST_TRAILING;
            end else if (nest_i.top_obj) begin
              if (char_i == ",") step_o.phase = PH_OBJ_KEY;
              else if (char_i == "}") step_o.pop = 1'b1;
              else step_o.err = ST_OBJ_SEP;
            end else begin
              if (char_i == ",") step_o.phase = PH_VALUE;
              else if (char_i == "]") step_o.pop = 1'b1;
              else step_o.err = ST_ARR_SEP;
            end
          end
        end
        PH_LIT: begin
          if (lit_prog_i < len && char_i == want) begin
            step_o.lit_prog = lit_prog_i + 3'd1;
            if (lit_prog_i + 3'd1 >= len) step_o.phase = PH_AFTER;
          end else begin
            step_o.err        = ST_LITERAL;
            step_o.err_at_tok = 1'b1;
          end
        end
        default: step_o.err = ST_UNEXP;
      endcase
    end
  end

  // Error that the end of text reveals in each phase.
  always_comb begin
    end_err_at_tok_o = 1'b0;
    case (phase_i)
      PH_VALUE, PH_ARR_FIRST:    end_err_o = ST_UNEXP;
      PH_OBJ_FIRST, PH_OBJ_KEY:  end_err_o = ST_QUOTE;
      PH_STR, PH_KEY:            end_err_o = ST_UNTERM;
      PH_STR_ESC, PH_KEY_ESC:    end_err_o = ST_ESC_END;
      PH_COLON:                  end_err_o = ST_COLON;
      PH_LIT: begin
        end_err_o        = ST_LITERAL;
        end_err_at_tok_o = 1'b1;
      end
      PH_NUM_SIGN:                   end_err_o = ST_NUMBER;
      PH_NUM_EXP, PH_NUM_EXP_SIGN:   end_err_o = ST_EXPONENT;
      PH_AFTER, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP_DIG: begin
        if (nest_i.empty) end_err_o = ST_OK;
        else end_err_o = nest_i.top_obj ? ST_OBJ_SEP : ST_ARR_SEP;
      end
      default: end_err_o = ST_UNEXP;
    endcase
  end

endmodule

// ===== rtl/core/json_syntax_validator.sv =====
// Top level of the streaming JSON syntax checker.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i, in_stall_o  | in_req_i  (mode, text_byte)
//   out     | output    | out_valid_o, out_stall_i| out_res_o (status, error_line, error_column)
//
// One request per cycle while the input is not stalled: a request is held in the input
// register and is parsed on its way to the result register, so an end-of-text result
// is registered once its request leaves the input register. The nesting stack reads
// its RAM every cycle. Reset clears all state but the data registers; the stack RAM
// needs no clearing. A stalled result holds the input register, and the input stalls
// only while that register is occupied and the result is stalled.
module json_syntax_validator #(
  parameter int MAX_DEPTH     = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jsv_pkg::jsv_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jsv_pkg::jsv_out_t out_res_o
);
  import jsv_pkg::*;

  localparam int PB = POSITION_BITS;

  logic           in_valid_q;
  jsv_in_t        in_q;
  logic           adv, fire, fire_end, fire_byte;
  logic [4:0]     phase_q;
  logic [1:0]     kind_q;
  logic [2:0]     prog_q;
  logic [PB-1:0]  line_q, col_q, tok_line_q, tok_col_q, err_line_q, err_col_q;
  logic [3:0]     err_q;
  jsv_step_t      step;
  logic [3:0]     end_err;
  logic           end_at_tok;
  jsv_nest_ctrl_t nest_ctrl;
  jsv_nest_stat_t nest_stat;
  logic           out_valid_q;
  jsv_out_t       out_q;
  logic [3:0]     fin_err;
  logic [PB-1:0]  fin_line, fin_col;

  // Input register handshake.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;
  assign fire       = in_valid_q && adv;
  assign fire_end   = fire && (in_q.mode == MODE_END);
  assign fire_byte  = fire && (in_q.mode == MODE_BYTE) && (err_q == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  jsv_parse u_parse (
    .phase_i          (phase_q),
    .char_i           (in_q.text_byte),
    .nest_i           (nest_stat),
    .lit_kind_i       (kind_q),
    .lit_prog_i       (prog_q),
    .step_o           (step),
    .end_err_o        (end_err),
    .end_err_at_tok_o (end_at_tok)
  );

  // Push and pop follow the parser while no error is latched; end of text clears the stack.
  assign nest_ctrl.clear    = fire_end;
  assign nest_ctrl.push     = fire_byte && step.push;
  assign nest_ctrl.pop      = fire_byte && step.pop;
  assign nest_ctrl.push_obj = step.push_obj;

  jsv_nest #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_nest (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nest_ctrl),
    .stat_o (nest_stat)
  );

  // Final status on end of text: an earlier error wins.
  always_comb begin
    fin_err  = err_q;
    fin_line = err_line_q;
    fin_col  = err_col_q;
    if (err_q == ST_OK && end_err != ST_OK) begin
      fin_err  = end_err;
      fin_line = end_at_tok ? tok_line_q : line_q;
      fin_col  = end_at_tok ? tok_col_q : col_q;
    end
  end

  // Parser state, positions and the latched error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VALUE;
      kind_q     <= '0;
      prog_q     <= '0;
      line_q     <= PB'(1);
      col_q      <= PB'(1);
      tok_line_q <= PB'(1);
      tok_col_q  <= PB'(1);
      err_q      <= ST_OK;
      err_line_q <= '0;
      err_col_q  <= '0;
    end else if (fire_end) begin
      phase_q    <= PH_VALUE;
      kind_q     <= '0;
      prog_q     <= '0;
      line_q     <= PB'(1);
      col_q      <= PB'(1);
      tok_line_q <= PB'(1);
      tok_col_q  <= PB'(1);
      err_q      <= ST_OK;
      err_line_q <= '0;
      err_col_q  <= '0;
    end else if (fire_byte) begin
      phase_q <= step.phase;
      kind_q  <= step.lit_kind;
      prog_q  <= step.lit_prog;
      if (step.tok_capture) begin
        tok_line_q <= line_q;
        tok_col_q  <= col_q;
      end
      if (step.err != ST_OK) begin
        err_q      <= step.err;
        err_line_q <= step.err_at_tok ? tok_line_q : line_q;
        err_col_q  <= step.err_at_tok ? tok_col_q : col_q;
      end
      if (in_q.text_byte == 8'h0a) begin
        if (line_q != '1) line_q <= line_q + 1'b1;
        col_q <= PB'(1);
      end else if (col_q != '1) begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_end) begin
      out_q.status       <= fin_err;
      out_q.error_line   <= (fin_err == ST_OK) ? 32'd0 : 32'(fin_line);
      out_q.error_column <= (fin_err == ST_OK) ? 32'd0 : 32'(fin_col);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // An accepted status places no position.
  a_ok_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.status == ST_OK) |->
      (out_res_o.error_line == 32'd0 && out_res_o.error_column == 32'd0))
    else $error("accepted result carries a position");

  // An end-of-text request always yields a result in the next cycle.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_end |=> out_valid_o)
    else $error("end of text gave no result");

  // A latched error holds until the end of text.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !fire_end) |=> (err_q == $past(err_q)))
    else $error("latched error changed");

  // The stack is never pushed beyond its depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_ctrl.push |-> !nest_stat.full)
    else $error("nesting stack overflow");

endmodule

// ===== verif/tb.sv =====
// Testbench for the streaming JSON syntax checker: scored against a local parser model.
`timescale 1ns / 100ps

module tb;
  import jsv_pkg::*;

  localparam int NEST_MAX = 64;

  // Holds the parser state and the queue of expected end-of-text results.
  class json_scoreboard;
    logic [4:0]  phase;
    bit          nest_obj [NEST_MAX];
    int unsigned level;
    int unsigned lit_kind;
    int unsigned lit_prog;
    logic [31:0] line_cnt, col_cnt, tok_line, tok_col;
    logic [3:0]  err_code;
    logic [31:0] err_line, err_col;
    jsv_out_t    pending_status [$];
    int          fail_count;

    function void clear_state();
      phase    = PH_VALUE;
      level    = 0;
      lit_kind = 0;
      lit_prog = 0;
      line_cnt = 1;
      col_cnt  = 1;
      tok_line = 1;
      tok_col  = 1;
      err_code = ST_OK;
      err_line = 0;
      err_col  = 0;
    endfunction

    function void latch_at(logic [3:0] code, logic [31:0] l, logic [31:0] c);
      if (err_code == ST_OK) begin
        err_code = code;
        err_line = l;
        err_col  = c;
      end
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit top_obj();
      return level != 0 && nest_obj[level - 1];
    endfunction

    function byte lit_expect(int unsigned k, int unsigned p);
      string s;
      s = (k == 0) ? "true" : (k == 1) ? "false" : "null";
      return (p < s.len()) ? s[p] : 8'h00;
    endfunction

    function void open_value(logic [7:0] c);
      if (c == "\"") begin
        phase = PH_STR;
      end else if (c == "{" || c == "[") begin
        if (level >= NEST_MAX) begin
          latch_at(ST_TOO_DEEP, line_cnt, col_cnt);
          return;
        end
        nest_obj[level] = (c == "{");
        level++;
        phase = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
      end else if (c == "t" || c == "f" || c == "n") begin
        lit_kind = (c == "t") ? 0 : (c == "f") ? 1 : 2;
        lit_prog = 1;
        tok_line = line_cnt;
        tok_col  = col_cnt;
        phase    = PH_LIT;
      end else if (c == "-") begin
        phase = PH_NUM_SIGN;
      end else if (is_digit(c)) begin
        phase = PH_NUM_INT;
      end else begin
        latch_at(ST_UNEXP, line_cnt, col_cnt);
      end
    endfunction

    function void close_level();
      if (level > 0) level--;
      phase = PH_AFTER;
    endfunction

    function void parse_byte(logic [7:0] c);
      int unsigned len;
      // Number phases either consume the byte or hand it on as the byte after a value.
      case (phase)
        PH_NUM_SIGN: begin
          if (is_digit(c)) phase = PH_NUM_INT;
          else latch_at(ST_NUMBER, line_cnt, col_cnt);
          return;
        end
        PH_NUM_INT: begin
          if (is_digit(c)) return;
          if (c == ".") begin phase = PH_NUM_FRAC; return; end
          if (c == "e" || c == "E") begin phase = PH_NUM_EXP; return; end
          phase = PH_AFTER;
        end
        PH_NUM_FRAC: begin
          if (is_digit(c)) return;
          if (c == "e" || c == "E") begin phase = PH_NUM_EXP; return; end
          phase = PH_AFTER;
        end
        PH_NUM_EXP: begin
          if (c == "+" || c == "-") phase = PH_NUM_EXP_SIGN;
          else if (is_digit(c)) phase = PH_NUM_EXP_DIG;
          else latch_at(ST_EXPONENT, line_cnt, col_cnt);
          return;
        end
        PH_NUM_EXP_SIGN: begin
          if (is_digit(c)) phase = PH_NUM_EXP_DIG;
          else latch_at(ST_EXPONENT, line_cnt, col_cnt);
          return;
        end
        PH_NUM_EXP_DIG: begin
          if (is_digit(c)) return;
          phase = PH_AFTER;
        end
        default: ;
      endcase

      case (phase)
        PH_VALUE: if (!is_space(c)) open_value(c);
        PH_ARR_FIRST: begin
          if (!is_space(c)) begin
            if (c == "]") close_level();
            else open_value(c);
          end
        end
        PH_OBJ_FIRST, PH_OBJ_KEY: begin
          if (!is_space(c)) begin
            if (c == "}" && phase == PH_OBJ_FIRST) close_level();
            else if (c == "\"") phase = PH_KEY;
            else latch_at(ST_QUOTE, line_cnt, col_cnt);
          end
        end
        PH_STR: begin
          if (c == "\"") phase = PH_AFTER;
          else if (c == "\\") phase = PH_STR_ESC;
        end
        PH_KEY: begin
          if (c == "\"") phase = PH_COLON;
          else if (c == "\\") phase = PH_KEY_ESC;
        end
        PH_STR_ESC, PH_KEY_ESC: begin
          if (c == "\"" || c == "\\") phase = (phase == PH_STR_ESC) ? PH_STR : PH_KEY;
          else latch_at(ST_BAD_ESC, line_cnt, col_cnt);
        end
        PH_COLON: begin
          if (!is_space(c)) begin
            if (c == ":") phase = PH_VALUE;
            else latch_at(ST_COLON, line_cnt, col_cnt);
          end
        end
        PH_AFTER: begin
          if (!is_space(c)) begin
            if (level == 0) latch_at(ST_TRAILING, line_cnt, col_cnt);
            else if (top_obj()) begin
              if (c == ",") phase = PH_OBJ_KEY;
              else if (c == "}") close_level();
              else latch_at(ST_OBJ_SEP, line_cnt, col_cnt);
            end else begin
              if (c == ",") phase = PH_VALUE;
              else if (c == "]") close_level();
              else latch_at(ST_ARR_SEP, line_cnt, col_cnt);
            end
          end
        end
        PH_LIT: begin
          len = (lit_kind == 1) ? 5 : 4;
          if (lit_prog < len && c == lit_expect(lit_kind, lit_prog)) begin
            lit_prog++;
            if (lit_prog >= len) phase = PH_AFTER;
          end else begin
            latch_at(ST_LITERAL, tok_line, tok_col);
          end
        end
        default: latch_at(ST_UNEXP, line_cnt, col_cnt);
      endcase
    endfunction

    function void finish_text();
      jsv_out_t r;
      case (phase)
        PH_VALUE, PH_ARR_FIRST:        latch_at(ST_UNEXP, line_cnt, col_cnt);
        PH_OBJ_FIRST, PH_OBJ_KEY:      latch_at(ST_QUOTE, line_cnt, col_cnt);
        PH_STR, PH_KEY:                latch_at(ST_UNTERM, line_cnt, col_cnt);
        PH_STR_ESC, PH_KEY_ESC:        latch_at(ST_ESC_END, line_cnt, col_cnt);
        PH_COLON:                      latch_at(ST_COLON, line_cnt, col_cnt);
        PH_LIT:                        latch_at(ST_LITERAL, tok_line, tok_col);
        PH_NUM_SIGN:                   latch_at(ST_NUMBER, line_cnt, col_cnt);
        PH_NUM_EXP, PH_NUM_EXP_SIGN:   latch_at(ST_EXPONENT, line_cnt, col_cnt);
        PH_AFTER, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP_DIG: begin
          if (level != 0) latch_at(top_obj() ? ST_OBJ_SEP : ST_ARR_SEP, line_cnt, col_cnt);
        end
        default:                       latch_at(ST_UNEXP, line_cnt, col_cnt);
      endcase
      r.status       = err_code;
      r.error_line   = (err_code != ST_OK) ? err_line : 32'd0;
      r.error_column = (err_code != ST_OK) ? err_col : 32'd0;
      pending_status.insert(pending_status.size(), r);
      clear_state();
    endfunction

    // Notes one accepted request.
    function void note_request(jsv_in_t req);
      if (req.mode == MODE_END) begin
        finish_text();
        return;
      end
      if (err_code != ST_OK) return;
      parse_byte(req.text_byte);
      if (req.text_byte == 8'h0a) begin
        if (line_cnt != 32'hffff_ffff) line_cnt++;
        col_cnt = 1;
      end else if (col_cnt != 32'hffff_ffff) begin
        col_cnt++;
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Checks one accepted result against the oldest expectation.
    task check_status(jsv_out_t got);
      jsv_out_t exp_r;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d", got.status));
        return;
      end
      exp_r = pending_status.pop_front();
      if (got.status !== exp_r.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, exp_r.status));
      if (got.error_line !== exp_r.error_line)
        report_mismatch($sformatf("line %0d, want %0d", got.error_line, exp_r.error_line));
      if (got.error_column !== exp_r.error_column)
        report_mismatch($sformatf("column %0d, want %0d", got.error_column,
                                  exp_r.error_column));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  jsv_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  jsv_out_t out_res_o;

  json_scoreboard sb;
  bit  quiet_phase;
  bit  hold_off;
  byte text_buf [$];

  json_syntax_validator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  // Clock generator.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Scoreboard taps on both handshakes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_status(out_res_o);
    end
  end

  // Sends one request and waits until it is taken, with an optional idle burst first.
  task automatic send_request(logic mode, logic [7:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_req_i.mode      <= mode;
    in_req_i.text_byte <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sends the buffered text followed by the end marker.
  task automatic send_text();
    foreach (text_buf[i]) send_request(MODE_BYTE, text_buf[i]);
    send_request(MODE_END, 8'($urandom_range(0, 255)));
    text_buf.delete();
  endtask

  // Appends one byte to the text being built.
  task automatic add_byte(byte b);
    text_buf.insert(text_buf.size(), b);
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic byte any_string_byte();
    byte b;
    do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  // Appends a random well-formed value, nested no deeper than the given budget.
  task automatic add_value(int depth);
    int sel;
    int n;
    sel = $urandom_range(0, (depth > 0) ? 7 : 5);
    if ($urandom_range(0, 3) == 0) add_string($urandom_range(0, 1) ? " " : "\n");
    case (sel)
      0: add_string("true");
      1: add_string("false");
      2: add_string("null");
      3: begin
        if ($urandom_range(0, 1)) add_string("-");
        n = $urandom_range(1, 4);
        repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          add_string(".");
          repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
          add_string($urandom_range(0, 1) ? "e" : "E");
          if ($urandom_range(0, 1)) add_string($urandom_range(0, 1) ? "+" : "-");
          repeat ($urandom_range(1, 2)) add_byte(8'("0" + $urandom_range(0, 9)));
        end
      end
      4, 5: begin
        add_string("\"");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 5) == 0) add_string($urandom_range(0, 1) ? "\\\"" : "\\\\");
          else add_byte(any_string_byte());
        end
        add_string("\"");
      end
      6: begin
        add_string("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i) add_string(",");
          add_value(depth - 1);
        end
        add_string("]");
      end
      default: begin
        add_string("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i) add_string(",");
          add_string(" \"k");
          add_byte(any_string_byte());
          add_string("\" :");
          add_value(depth - 1);
        end
        add_string("}");
      end
    endcase
    if ($urandom_range(0, 3) == 0) add_string($urandom_range(0, 1) ? "\t" : "\r");
  endtask

  // Builds a random text: mostly valid, some with a damaged byte, an extra byte or cut short.
  task automatic add_random_text();
    int kind;
    int pos;
    kind = $urandom_range(0, 9);
    add_value($urandom_range(0, 4));
    if (kind == 0) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      text_buf[pos] = 8'($urandom_range(0, 255));
    end else if (kind == 1) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      while (text_buf.size() > pos) void'(text_buf.pop_back());
    end else if (kind == 2) begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver stall: random bursts, or a long hold-off when asked.
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Main sequence.
  initial begin
    int wait_cycles;
    sb = new();
    sb.clear_state();
    sb.fail_count = 0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts covering every status.
    add_string("{\"a\\\\\":[1,-0.e+5,true,null,\"x\\\"\"]}"); send_text();
    add_string("1 2");         send_text();
    add_string("\n  ?");       send_text();
    add_string(" trux");       send_text();
    add_string("{\"a\" 1}");   send_text();
    add_string("{\"a\":1 ]");  send_text();
    add_string("[1 }");        send_text();
    add_string("-x");          send_text();
    add_string("1e+");         send_text();
    add_string("{1}");         send_text();
    add_string("\"ab\\");      send_text();
    add_string("\"\\n\"");     send_text();
    add_string("\"abc");       send_text();
    add_string("fals");        send_text();
    add_string("");            send_text();
    add_byte(8'hff); send_text();
    add_byte(8'h80); add_byte(8'h7f); send_text();
    repeat (NEST_MAX) add_string("[");
    repeat (NEST_MAX) add_string("]");
    send_text();
    repeat (NEST_MAX + 1) add_string("{\"k\":");
    send_text();
    add_string("[{}");         send_text();

    // Random texts; a long receiver hold-off partway through.
    for (int t = 0; t < 40; t++) begin
      if (t == 10) hold_off = 1'b1;
      if (t == 34) quiet_phase = 1'b1;
      add_random_text();
      send_text();
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_status.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending_status.size() != 0) sb.report_mismatch("results still outstanding");
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
